/* sv/i2cm_pkg.sv */
// Shared types, codes and constants for the I2C register byte master.
package i2cm_pkg;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_DATA_W  = 16;

    localparam logic [15:0] DELAY_TICKS_RESET    = 16'd150;
    localparam logic [7:0]  ACK_POLL_LIMIT_RESET = 8'd250;

    // Configuration register indexes.
    localparam logic CFG_DELAY_TICKS    = 1'b0;
    localparam logic CFG_ACK_POLL_LIMIT = 1'b1;

    // Command codes.
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Transfer stages within one transaction.
    localparam logic [1:0] STAGE_DEVICE   = 2'd0;
    localparam logic [1:0] STAGE_REGISTER = 2'd1;
    localparam logic [1:0] STAGE_THIRD    = 2'd2;
    localparam logic [1:0] STAGE_RECEIVE  = 2'd3;

    // Status codes.
    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_DEVICE_NACK = 2'd1;
    localparam logic [1:0] STATUS_REG_NACK    = 2'd2;
    localparam logic [1:0] STATUS_RADDR_NACK  = 2'd3;

    typedef enum logic [4:0] {
        PH_IDLE = 5'd0,
        PH_ST1  = 5'd1,
        PH_ST2  = 5'd2,
        PH_ST3  = 5'd3,
        PH_ST4  = 5'd4,
        PH_TX1  = 5'd5,
        PH_TX2  = 5'd6,
        PH_TX3  = 5'd7,
        PH_AK1  = 5'd8,
        PH_AK2  = 5'd9,
        PH_AK3  = 5'd10,
        PH_AK4  = 5'd11,
        PH_SP1  = 5'd12,
        PH_SP2  = 5'd13,
        PH_SP3  = 5'd14,
        PH_RX1  = 5'd15,
        PH_RX2  = 5'd16,
        PH_RX3  = 5'd17,
        PH_NA1  = 5'd18,
        PH_NA2  = 5'd19,
        PH_NA3  = 5'd20
    } phase_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_pull_low;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] read_byte;
    } result_t;

endpackage

/* sv/i2c_register_byte_master.sv */
// Top level of the single-byte I2C register write/read master.
//
//  channel  | direction | contents
//  ---------+-----------+------------------------------------------------------
//  s_*      | in        | one bus tick with an optional command
//  m_*      | out       | line drive levels and transaction status for that tick
//  cfg_*    | in        | writes to delay_ticks (index 0) and ack_poll_limit (1)
//
// Each input word is handled combinationally; its registered result word follows
// in the next cycle, and a new word is taken every cycle while output is drained.
// The sequencer state register is the only loop, so the rate is one word a cycle.
// A stalled output holds its word and lowers s_tready until it is taken.
// After reset SCL and SDA are released, the block is idle and no result is held.
module i2c_register_byte_master
    import i2cm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [7:0] device_address, [15:8] register_address, [23:16] write_data,
    // [24] sda_in, [31:25] zero
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // [1:0] command
    input  logic [1:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] scl_level, [1] sda_pull_low, [2] busy_res, [3] done_res,
    // [5:4] status, [13:6] read_byte, [15:14] zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_we,
    input  logic                   cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    result_t res;
    logic    load;

    i2cm_seq u_seq (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .step             (load),
        .command          (s_tuser),
        .device_address   (s_tdata[7:0]),
        .register_address (s_tdata[15:8]),
        .write_data       (s_tdata[23:16]),
        .sda_in           (s_tdata[24]),
        .res              (res)
    );

    i2cm_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .res      (res),
        .m_tready (m_tready),
        .in_ready (s_tready),
        .load     (load),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTHESIS
    // When no transaction is in progress both lines must be released.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[2] |-> m_tdata[0] && !m_tdata[1])
        else $error("idle result does not release SCL and SDA");

    // An accepted tick always produces a result word in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted word produced no result");

    // A done pulse lasts a single tick: the tick after it is idle or newly busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        load && res.done_res |=> !res.done_res)
        else $error("done pulse longer than one tick");
`endif

endmodule

/* sv/i2cm_seq.sv */
// Bus sequencer: configuration registers, transaction state and per-tick result.
module i2cm_seq
    import i2cm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  step,
    input  logic [1:0]            command,
    input  logic [7:0]            device_address,
    input  logic [7:0]            register_address,
    input  logic [7:0]            write_data,
    input  logic                  sda_in,
    output result_t               res
);

    logic [15:0] delay_ticks_reg;
    logic [7:0]  ack_poll_limit_reg;

    phase_t      phase_reg, phase_c, phase_next;
    logic [3:0]  bit_count_reg, bit_count_c, bit_count_next;
    logic [7:0]  shift_reg_reg, shift_reg_c, shift_reg_next;
    logic [15:0] delay_count_reg, delay_count_c, delay_count_next;
    logic [7:0]  ack_count_reg, ack_count_next;
    logic [7:0]  saved_device_reg, saved_device_c;
    logic [7:0]  saved_register_reg, saved_register_c;
    logic [7:0]  saved_data_reg, saved_data_c;
    logic        is_read_reg, is_read_c;
    logic [7:0]  received_reg, received_next;
    logic [1:0]  last_status_reg, last_status_next;
    logic [1:0]  stage_reg, stage_c, stage_next;
    logic [1:0]  units_left_reg, units_left_c, units_left_next;
    logic        ack_failed_reg, ack_failed_next;
    logic        done_pending_reg, done_pending_next;
    logic        scl_out_reg, scl_out_next;
    logic        sda_low_reg, sda_low_c, sda_low_next;

    logic        start;
    logic [15:0] unit_ticks;
    logic [16:0] delay_inc;
    logic [7:0]  ack_inc;
    logic [1:0]  units_dec;
    logic [3:0]  bit_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_ticks_reg    <= DELAY_TICKS_RESET;
            ack_poll_limit_reg <= ACK_POLL_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_DELAY_TICKS:    delay_ticks_reg    <= cfg_wdata;
                CFG_ACK_POLL_LIMIT: ack_poll_limit_reg <= cfg_wdata[7:0];
                default:            delay_ticks_reg    <= delay_ticks_reg;
            endcase
        end
    end

    // A command is taken only from idle; busy ticks ignore it.
    always_comb
    begin
        start            = (phase_reg == PH_IDLE) &&
                           ((command == CMD_WRITE) || (command == CMD_READ));
        phase_c          = phase_reg;
        stage_c          = stage_reg;
        bit_count_c      = bit_count_reg;
        shift_reg_c      = shift_reg_reg;
        units_left_c     = units_left_reg;
        delay_count_c    = delay_count_reg;
        sda_low_c        = sda_low_reg;
        saved_device_c   = saved_device_reg;
        saved_register_c = saved_register_reg;
        saved_data_c     = saved_data_reg;
        is_read_c        = is_read_reg;
        if (start)
        begin
            saved_device_c   = device_address;
            saved_register_c = register_address;
            saved_data_c     = write_data;
            is_read_c        = (command == CMD_READ);
            stage_c          = STAGE_DEVICE;
            bit_count_c      = 4'd0;
            shift_reg_c      = device_address;
            phase_c          = PH_ST1;
            units_left_c     = 2'd1;
            delay_count_c    = 16'd0;
            sda_low_c        = 1'b0;
        end
    end

    // Result shows the line levels during this tick.
    always_comb
    begin
        res.scl_level    = scl_out_reg;
        res.sda_pull_low = sda_low_c;
        res.busy_res     = (phase_c != PH_IDLE);
        res.done_res     = done_pending_reg;
        res.status       = last_status_reg;
        res.read_byte    = received_reg;
    end

    always_comb
    begin
        unit_ticks        = (delay_ticks_reg == 16'd0) ? 16'd1 : delay_ticks_reg;
        delay_inc         = {1'b0, delay_count_c} + 17'd1;
        ack_inc           = ack_count_reg + 8'd1;
        units_dec         = (units_left_c != 2'd0) ? units_left_c - 2'd1 : 2'd0;
        bit_inc           = bit_count_c + 4'd1;

        phase_next        = phase_c;
        stage_next        = stage_c;
        bit_count_next    = bit_count_c;
        shift_reg_next    = shift_reg_c;
        units_left_next   = units_left_c;
        delay_count_next  = delay_count_c;
        ack_count_next    = ack_count_reg;
        received_next     = received_reg;
        last_status_next  = last_status_reg;
        ack_failed_next   = ack_failed_reg;
        done_pending_next = 1'b0;
        scl_out_next      = scl_out_reg;
        sda_low_next      = sda_low_c;

        if (phase_c == PH_AK3)
        begin
            if (!sda_in || (ack_inc >= ack_poll_limit_reg))
            begin
                ack_failed_next  = sda_in;
                phase_next       = PH_AK4;
                units_left_next  = 2'd1;
                delay_count_next = 16'd0;
                scl_out_next     = 1'b0;
            end
            if (sda_in)
            begin
                ack_count_next = ack_inc;
            end
        end
        else if (phase_c != PH_IDLE)
        begin
            delay_count_next = delay_inc[15:0];
            if (delay_inc >= {1'b0, unit_ticks})
            begin
                delay_count_next = 16'd0;
                units_left_next  = units_dec;
                if (units_dec == 2'd0)
                begin
                    // Every phase change restarts the tick count.
                    units_left_next = 2'd1;
                    unique case (phase_c)
                        PH_ST1:
                        begin
                            phase_next      = PH_ST2;
                            units_left_next = 2'd2;
                            scl_out_next    = 1'b1;
                        end
                        PH_ST2:
                        begin
                            phase_next      = PH_ST3;
                            units_left_next = 2'd2;
                            sda_low_next    = 1'b1;
                        end
                        PH_ST3:
                        begin
                            phase_next   = PH_ST4;
                            scl_out_next = 1'b0;
                        end
                        PH_ST4:
                        begin
                            bit_count_next = 4'd0;
                            phase_next     = PH_TX1;
                        end
                        PH_TX1:
                        begin
                            phase_next   = PH_TX2;
                            scl_out_next = 1'b0;
                            sda_low_next = ~shift_reg_c[7];
                        end
                        PH_TX2:
                        begin
                            phase_next      = PH_TX3;
                            units_left_next = 2'd2;
                            scl_out_next    = 1'b1;
                        end
                        PH_TX3:
                        begin
                            shift_reg_next = {shift_reg_c[6:0], 1'b0};
                            bit_count_next = bit_inc;
                            scl_out_next   = 1'b0;
                            if (bit_inc < 4'd8)
                            begin
                                phase_next = PH_TX1;
                            end
                            else
                            begin
                                phase_next   = PH_AK1;
                                sda_low_next = 1'b0;
                            end
                        end
                        PH_AK1:
                        begin
                            ack_count_next = 8'd0;
                            phase_next     = PH_AK2;
                            scl_out_next   = 1'b1;
                        end
                        PH_AK2:
                        begin
                            phase_next      = PH_AK3;
                            units_left_next = 2'd0;
                            scl_out_next    = 1'b1;
                        end
                        PH_AK4:
                        begin
                            // A failed ack on the data byte of a write is ignored.
                            if (ack_failed_reg &&
                                !((stage_c == STAGE_THIRD) && !is_read_c))
                            begin
                                if (stage_c == STAGE_DEVICE)
                                    last_status_next = STATUS_DEVICE_NACK;
                                else if (stage_c == STAGE_REGISTER)
                                    last_status_next = STATUS_REG_NACK;
                                else
                                    last_status_next = STATUS_RADDR_NACK;
                                phase_next   = PH_SP1;
                                scl_out_next = 1'b0;
                                sda_low_next = 1'b1;
                            end
                            else if (stage_c == STAGE_DEVICE)
                            begin
                                stage_next     = STAGE_REGISTER;
                                shift_reg_next = saved_register_c;
                                bit_count_next = 4'd0;
                                phase_next     = PH_TX1;
                            end
                            else if (stage_c == STAGE_REGISTER)
                            begin
                                stage_next     = STAGE_THIRD;
                                bit_count_next = 4'd0;
                                if (is_read_c)
                                begin
                                    shift_reg_next = saved_device_c + 8'd1;
                                    phase_next     = PH_ST1;
                                    sda_low_next   = 1'b0;
                                end
                                else
                                begin
                                    shift_reg_next = saved_data_c;
                                    phase_next     = PH_TX1;
                                end
                            end
                            else if (is_read_c)
                            begin
                                stage_next     = STAGE_RECEIVE;
                                bit_count_next = 4'd0;
                                shift_reg_next = 8'd0;
                                phase_next     = PH_RX1;
                                scl_out_next   = 1'b0;
                                sda_low_next   = 1'b0;
                            end
                            else
                            begin
                                last_status_next = STATUS_OK;
                                phase_next       = PH_SP1;
                                scl_out_next     = 1'b0;
                                sda_low_next     = 1'b1;
                            end
                        end
                        PH_SP1:
                        begin
                            phase_next   = PH_SP2;
                            scl_out_next = 1'b1;
                        end
                        PH_SP2:
                        begin
                            phase_next   = PH_SP3;
                            sda_low_next = 1'b0;
                        end
                        PH_SP3:
                        begin
                            phase_next        = PH_IDLE;
                            units_left_next   = 2'd0;
                            scl_out_next      = 1'b1;
                            sda_low_next      = 1'b0;
                            done_pending_next = 1'b1;
                        end
                        PH_RX1:
                        begin
                            phase_next   = PH_RX2;
                            scl_out_next = 1'b1;
                        end
                        PH_RX2:
                        begin
                            shift_reg_next = {shift_reg_c[6:0], sda_in};
                            phase_next     = PH_RX3;
                            scl_out_next   = 1'b0;
                        end
                        PH_RX3:
                        begin
                            bit_count_next = bit_inc;
                            scl_out_next   = 1'b0;
                            sda_low_next   = 1'b0;
                            if (bit_inc < 4'd8)
                            begin
                                phase_next = PH_RX1;
                            end
                            else
                            begin
                                received_next    = shift_reg_c;
                                last_status_next = STATUS_OK;
                                phase_next       = PH_NA1;
                            end
                        end
                        PH_NA1:
                        begin
                            phase_next   = PH_NA2;
                            scl_out_next = 1'b1;
                        end
                        PH_NA2:
                        begin
                            phase_next   = PH_NA3;
                            scl_out_next = 1'b0;
                        end
                        PH_NA3:
                        begin
                            phase_next   = PH_SP1;
                            scl_out_next = 1'b0;
                            sda_low_next = 1'b1;
                        end
                        default:
                        begin
                            phase_next      = PH_IDLE;
                            units_left_next = 2'd0;
                            scl_out_next    = 1'b1;
                            sda_low_next    = 1'b0;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            stage_reg          <= STAGE_DEVICE;
            bit_count_reg      <= 4'd0;
            shift_reg_reg      <= 8'd0;
            units_left_reg     <= 2'd0;
            delay_count_reg    <= 16'd0;
            ack_count_reg      <= 8'd0;
            saved_device_reg   <= 8'd0;
            saved_register_reg <= 8'd0;
            saved_data_reg     <= 8'd0;
            is_read_reg        <= 1'b0;
            received_reg       <= 8'd0;
            last_status_reg    <= STATUS_OK;
            ack_failed_reg     <= 1'b0;
            done_pending_reg   <= 1'b0;
            scl_out_reg        <= 1'b1;
            sda_low_reg        <= 1'b0;
        end
        else if (step)
        begin
            phase_reg          <= phase_next;
            stage_reg          <= stage_next;
            bit_count_reg      <= bit_count_next;
            shift_reg_reg      <= shift_reg_next;
            units_left_reg     <= units_left_next;
            delay_count_reg    <= delay_count_next;
            ack_count_reg      <= ack_count_next;
            saved_device_reg   <= saved_device_c;
            saved_register_reg <= saved_register_c;
            saved_data_reg     <= saved_data_c;
            is_read_reg        <= is_read_c;
            received_reg       <= received_next;
            last_status_reg    <= last_status_next;
            ack_failed_reg     <= ack_failed_next;
            done_pending_reg   <= done_pending_next;
            scl_out_reg        <= scl_out_next;
            sda_low_reg        <= sda_low_next;
        end
    end

endmodule

/* sv/i2cm_out_stage.sv */
// Result register that decouples the input side from a stalled output side.
module i2cm_out_stage
    import i2cm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  result_t                res,
    input  logic                   m_tready,
    output logic                   in_ready,
    output logic                   load,
    output logic                   m_tvalid,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    // A new word can enter whenever the held one is empty or leaving.
    assign in_ready = !m_tvalid_reg || m_tready;
    assign load     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            m_tvalid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            m_tdata_reg <= {2'b00, res.read_byte, res.status, res.done_res,
                            res.busy_res, res.sda_pull_low, res.scl_level};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
